FILE: sv/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur.
// Used by bb3_linebuf, bb3_lane and box_blur_3x3_edge_mean_top; depends on nothing.
package bb3_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int CH_W          = 8;
	localparam int PIX_W         = 3 * CH_W;
	localparam int FW_W          = 11;
	localparam int FH_W          = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Number of window neighbours that exist for the current output pixel.
	typedef logic [1:0] bb3_cnt_t;
	localparam bb3_cnt_t CNT_4 = 2'd0;
	localparam bb3_cnt_t CNT_6 = 2'd1;
	localparam bb3_cnt_t CNT_9 = 2'd2;

	// Window sum and rounding: mean = floor((2*sum + n) / (2*n)), done as a
	// multiply by a scaled reciprocal and a right shift.
	localparam int SUM_W       = 12;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 16;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 17;
	localparam logic [RECIP_W-1:0] RECIP_4 = 16'd32768;
	localparam logic [RECIP_W-1:0] RECIP_6 = 16'd21846;
	localparam logic [RECIP_W-1:0] RECIP_18 = 16'd7282;

	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} bb3_edges_t;

	typedef struct packed {
		logic       shift_en;
		logic       sum_en;
		logic       mean_en;
		bb3_edges_t edges;
		bb3_cnt_t   cnt;
	} bb3_lane_ctrl_t;

endpackage

FILE: sv/bb3_linebuf.sv
// Two line stores holding the previous two image rows, with a bypass for a
// read that hits the entry being written in the same cycle.
// Depends on bb3_pkg.
module bb3_linebuf import bb3_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  logic [PIX_W-1:0]         wr_pix,
	output logic [PIX_W-1:0]         up,
	output logic [PIX_W-1:0]         lo
);

	logic [PIX_W-1:0] mem_up [DEPTH];
	logic [PIX_W-1:0] mem_lo [DEPTH];
	logic [PIX_W-1:0] up_rd_q;
	logic [PIX_W-1:0] lo_rd_q;
	logic [PIX_W-1:0] byp_up_q;
	logic [PIX_W-1:0] byp_lo_q;
	logic             byp_q;

	// The upper store takes the old lower row, the lower store the new pixel.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_up[wr_idx] <= lo;
		end
		if (rd_en) begin
			up_rd_q <= mem_up[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_lo[wr_idx] <= wr_pix;
		end
		if (rd_en) begin
			lo_rd_q <= mem_lo[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_idx == rd_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_up_q <= lo;
			byp_lo_q <= wr_pix;
		end
	end

	assign up = byp_q ? byp_up_q : up_rd_q;
	assign lo = byp_q ? byp_lo_q : lo_rd_q;

endmodule

FILE: sv/bb3_lane.sv
// One color channel of the blur: 3x3 window, masked window sum and the
// rounded mean by reciprocal multiply. Depends on bb3_pkg.
module bb3_lane import bb3_pkg::*; (
	input  logic            clk,
	input  bb3_lane_ctrl_t  ctrl,
	input  logic [CH_W-1:0] up_px,
	input  logic [CH_W-1:0] lo_px,
	input  logic [CH_W-1:0] in_px,
	output logic [CH_W-1:0] mean
);

	logic [CH_W-1:0]    win_q [3][3];
	logic [2:0]         row_ok;
	logic [2:0]         col_ok;
	logic [SUM_W-1:0]   sum_c;
	logic [SUM_W-1:0]   sum_s3;
	logic [NUM_W-1:0]   num;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod;
	logic [CH_W-1:0]    mean_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_px;
			win_q[1][2] <= lo_px;
			win_q[2][2] <= in_px;
		end
	end

	assign row_ok = {~ctrl.edges.bot, 1'b1, ~ctrl.edges.top};
	assign col_ok = {~ctrl.edges.right, 1'b1, ~ctrl.edges.left};

	always_comb begin
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_c = sum_c + SUM_W'(win_q[r][c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			sum_s3 <= sum_c;
		end
	end

	// Interior pixels divide (2*sum + 9) by 18; edges and corners fold the
	// factor of two into the bias.
	always_comb begin
		case (ctrl.cnt)
			CNT_9: begin
				num   = {sum_s3, 1'b0} + NUM_W'(9);
				recip = RECIP_18;
			end
			CNT_6: begin
				num   = NUM_W'(sum_s3) + NUM_W'(3);
				recip = RECIP_6;
			end
			default: begin
				num   = NUM_W'(sum_s3) + NUM_W'(2);
				recip = RECIP_4;
			end
		endcase
	end

	assign prod = PROD_W'(num) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (ctrl.mean_en) begin
			mean_q <= prod[RECIP_SHIFT +: CH_W];
		end
	end

	assign mean = mean_q;

endmodule

FILE: sv/box_blur_3x3_edge_mean_top.sv
// Streaming 3x3 box blur for 24-bit RGB pixels with edge-aware averaging.
// Depends on bb3_pkg, bb3_linebuf and bb3_lane.
//
// Usage:
// Pixels enter in raster order on the in_valid/in_ready channel, one request
// per pixel; drain=1 marks a flush request whose channels count as zero.
// After the last pixel of a frame, send frame_width+1 drain requests.
// Blurred pixels leave on the out_valid/out_ready channel; frame_end flags
// the last pixel of a frame. A pixel's result is triggered by the request
// that arrives frame_width+1 positions after it and is then registered in
// turn by the input, window shift, sum and divide stages.
// Throughput is one request per clock while the receiver does not stall: each
// line store is read once at acceptance and written once in the following stage.
// The configuration port writes frame_width and frame_height; write them only
// while no request is in flight.
// Reset clears the position counters and pipeline, and sets both registers to
// 1024. The line stores are not cleared; entries not yet written only reach
// window positions that are excluded from the mean.
// When the receiver stalls, the result waits in the output register and the
// three internal stages keep filling; in_ready drops once all are full.
module box_blur_3x3_edge_mean_top import bb3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CH_W-1:0]      in_red,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_blue,
	input  logic                 drain,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue,
	output logic                 frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [WW-1:0]    fw_ext;
	logic [WW-1:0]    w_eff;
	logic [CW-1:0]    wlast;
	logic [FH_W-1:0]  hlast;

	logic [CW-1:0]    in_column_q, in_column_d;
	logic [FH_W-1:0]  in_row_q, in_row_d;
	logic [CW-1:0]    out_column_q, out_column_d;
	logic [FH_W-1:0]  out_row_q, out_row_d;

	logic             emit_now;
	logic             last_now;
	bb3_edges_t       edge_now;
	logic [PIX_W-1:0] pix_now;

	logic             valid_s1, valid_s2, valid_s3, valid_q;
	logic             acc, adv1, adv2, adv3;
	logic             rdy2, rdy3, rdy_o;

	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    idx_s1;
	logic             emit_s1;
	logic             last_s1, last_s2, last_s3;
	bb3_edges_t       edge_s1, edge_s2;
	bb3_cnt_t         cnt_s2, cnt_s3;
	logic             frame_end_q;

	logic [PIX_W-1:0] up_px;
	logic [PIX_W-1:0] lo_px;
	bb3_lane_ctrl_t   lane_ctrl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(1024);
			frame_height_q <= FH_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		fw_ext = WW'(frame_width_q);
		if (fw_ext < WW'(2)) begin
			w_eff = WW'(2);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
	end

	assign wlast = CW'(w_eff - WW'(1));
	assign hlast = (frame_height_q < FH_W'(2)) ? FH_W'(1) : frame_height_q - FH_W'(1);

	// Handshake: each stage moves when the next one is empty or moving.
	assign rdy_o    = !valid_q || out_ready;
	assign rdy3     = !valid_s3 || rdy_o;
	assign rdy2     = !valid_s2 || rdy3;
	assign in_ready = !valid_s1 || rdy2;
	assign acc      = in_valid && in_ready;
	assign adv1     = valid_s1 && rdy2;
	assign adv2     = valid_s2 && rdy3;
	assign adv3     = valid_s3 && rdy_o;

	// Raster positions of the incoming request and of the next result.
	always_comb begin
		emit_now       = (in_row_q >= FH_W'(2)) || (in_row_q == FH_W'(1) && in_column_q != '0);
		edge_now.top   = (out_row_q == '0);
		edge_now.bot   = (out_row_q >= hlast);
		edge_now.left  = (out_column_q == '0);
		edge_now.right = (out_column_q >= wlast);
		last_now       = emit_now && edge_now.right && edge_now.bot;

		if (in_column_q >= wlast) begin
			in_column_d = '0;
			in_row_d    = (in_row_q == '1) ? in_row_q : in_row_q + FH_W'(1);
		end else begin
			in_column_d = in_column_q + CW'(1);
			in_row_d    = in_row_q;
		end
		out_column_d = out_column_q;
		out_row_d    = out_row_q;

		if (emit_now) begin
			if (last_now) begin
				in_column_d  = '0;
				in_row_d     = '0;
				out_column_d = '0;
				out_row_d    = '0;
			end else if (edge_now.right) begin
				out_column_d = '0;
				out_row_d    = out_row_q + FH_W'(1);
			end else begin
				out_column_d = out_column_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			in_row_q     <= '0;
			out_column_q <= '0;
			out_row_q    <= '0;
		end else if (acc) begin
			in_column_q  <= in_column_d;
			in_row_q     <= in_row_d;
			out_column_q <= out_column_d;
			out_row_q    <= out_row_d;
		end
	end

	assign pix_now = drain ? '0 : {in_red, in_green, in_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			// Requests that produce no result drop out after the window shift.
			if (adv1) begin
				valid_s2 <= emit_s1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				valid_s3 <= 1'b1;
			end else if (adv3) begin
				valid_s3 <= 1'b0;
			end
			if (adv3) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case ({2'b00, edge_s2.top} + {2'b00, edge_s2.bot}
			+ {2'b00, edge_s2.left} + {2'b00, edge_s2.right})
			3'd0:    cnt_s2 = CNT_9;
			3'd1:    cnt_s2 = CNT_6;
			default: cnt_s2 = CNT_4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pix_now;
			idx_s1  <= in_column_q;
			emit_s1 <= emit_now;
			edge_s1 <= edge_now;
			last_s1 <= last_now;
		end
		if (adv1) begin
			edge_s2 <= edge_s1;
			last_s2 <= last_s1;
		end
		if (adv2) begin
			cnt_s3  <= cnt_s2;
			last_s3 <= last_s2;
		end
		if (adv3) begin
			frame_end_q <= last_s3;
		end
	end

	bb3_linebuf #(
		.DEPTH(MAX_WIDTH)
	) u_linebuf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (acc),
		.rd_idx (in_column_q),
		.wr_en  (adv1),
		.wr_idx (idx_s1),
		.wr_pix (pix_s1),
		.up     (up_px),
		.lo     (lo_px)
	);

	assign lane_ctrl.shift_en = adv1;
	assign lane_ctrl.sum_en   = adv2;
	assign lane_ctrl.mean_en  = adv3;
	assign lane_ctrl.edges    = edge_s2;
	assign lane_ctrl.cnt      = cnt_s3;

	bb3_lane u_lane_red (
		.clk   (clk),
		.ctrl  (lane_ctrl),
		.up_px (up_px[2*CH_W +: CH_W]),
		.lo_px (lo_px[2*CH_W +: CH_W]),
		.in_px (pix_s1[2*CH_W +: CH_W]),
		.mean  (out_red)
	);

	bb3_lane u_lane_green (
		.clk   (clk),
		.ctrl  (lane_ctrl),
		.up_px (up_px[CH_W +: CH_W]),
		.lo_px (lo_px[CH_W +: CH_W]),
		.in_px (pix_s1[CH_W +: CH_W]),
		.mean  (out_green)
	);

	bb3_lane u_lane_blue (
		.clk   (clk),
		.ctrl  (lane_ctrl),
		.up_px (up_px[0 +: CH_W]),
		.lo_px (lo_px[0 +: CH_W]),
		.in_px (pix_s1[0 +: CH_W]),
		.mean  (out_blue)
	);

	assign out_valid = valid_q;
	assign frame_end = frame_end_q;

	// The last result of a frame returns every position counter to zero.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_now) |=> (in_column_q == '0 && in_row_q == '0
			&& out_column_q == '0 && out_row_q == '0))
		else $error("position counters not cleared after frame end");

	// A stalled output must not let the stage behind it overwrite it.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready && valid_s3) |=> (valid_q && valid_s3))
		else $error("result lost while output stalled");

	// With every stage full and the receiver stalled, no request may enter.
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_q && !out_ready) |-> !in_ready)
		else $error("request accepted into a full pipeline");

endmodule

FILE: tb/tb_box_blur_3x3_edge_mean_top.sv
// Self-checking testbench for box_blur_3x3_edge_mean_top: a queue-fed request driver,
// a result monitor and a cycle-free blur predictor with its own line stores and counters.
// Depends on bb3_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_mean_top;
	import bb3_pkg::*;

	localparam int MAX_W = MAX_WIDTH_DEF;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            drain;
	} pixel_req_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blur_res_t;

	typedef enum {FILL_RANDOM, FILL_WHITE, FILL_CHECKER} fill_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [CH_W-1:0]      in_red    = '0;
	logic [CH_W-1:0]      in_green  = '0;
	logic [CH_W-1:0]      in_blue   = '0;
	logic                 drain     = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic                 frame_end;

	box_blur_3x3_edge_mean_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.drain     (drain),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_end (frame_end)
	);

	// Blur predictor state, mirroring the block's registers and line stores.
	logic [FW_W-1:0]  width_reg  = 11'd1024;
	logic [FH_W-1:0]  height_reg = 16'd1024;
	logic [PIX_W-1:0] upper_line [MAX_W] = '{default: '0};
	logic [PIX_W-1:0] lower_line [MAX_W] = '{default: '0};
	logic [PIX_W-1:0] win [3][3] = '{default: '0};
	int unsigned      col_in  = 0;
	int unsigned      row_in  = 0;
	int unsigned      col_out = 0;
	int unsigned      row_out = 0;

	pixel_req_t  pixel_q [$];
	blur_res_t   blurred_q [$];
	pixel_req_t  cur_req;
	blur_res_t   want;
	int unsigned n_queued   = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked  = 0;
	int unsigned n_frames   = 0;
	int unsigned n_errors   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned eff_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < 2) return 2;
		return height_reg;
	endfunction

	function automatic logic [CH_W-1:0] window_mean(int unsigned lsb, int unsigned r0,
			int unsigned r1, int unsigned c0, int unsigned c1);
		int unsigned sum, cnt, r, c;
		sum = 0;
		cnt = 0;
		for (r = r0; r <= r1; r++) begin
			for (c = c0; c <= c1; c++) begin
				sum += win[r][c][lsb +: CH_W];
				cnt++;
			end
		end
		// Half-up rounding done exactly in integers.
		return CH_W'((2 * sum + cnt) / (2 * cnt));
	endfunction

	function automatic void blur_step(pixel_req_t req);
		int unsigned w, h, idx, r, r0, r1, c0, c1;
		logic [PIX_W-1:0] px, up, lo;
		bit emit, fin;
		blur_res_t res;
		w = eff_width();
		h = eff_height();
		px = req.drain ? '0 : {req.red, req.green, req.blue};
		idx = (col_in < MAX_W) ? col_in : 0;
		up = upper_line[idx];
		lo = lower_line[idx];
		upper_line[idx] = lo;
		lower_line[idx] = px;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = lo;
		win[2][2] = px;
		emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
		if (col_in >= w - 1) begin
			col_in = 0;
			if (row_in < 65535) row_in++;
		end else begin
			col_in++;
		end
		if (!emit) return;
		r0 = (row_out == 0) ? 1 : 0;
		r1 = (row_out >= h - 1) ? 1 : 2;
		c0 = (col_out == 0) ? 1 : 0;
		c1 = (col_out >= w - 1) ? 1 : 2;
		res.red   = window_mean(16, r0, r1, c0, c1);
		res.green = window_mean(8, r0, r1, c0, c1);
		res.blue  = window_mean(0, r0, r1, c0, c1);
		fin = col_out >= w - 1 && row_out >= h - 1;
		res.last = fin;
		blurred_q.push_back(res);
		if (fin) begin
			col_in = 0;
			row_in = 0;
			col_out = 0;
			row_out = 0;
		end else if (col_out >= w - 1) begin
			col_out = 0;
			row_out++;
		end else begin
			col_out++;
		end
	endfunction

	// Counts the items that bring the position counters back to the start of a frame.
	function automatic int unsigned drains_to_frame_start();
		int unsigned ic = col_in;
		int unsigned ir = row_in;
		int unsigned oc = col_out;
		int unsigned orow = row_out;
		int unsigned w = eff_width();
		int unsigned h = eff_height();
		int unsigned n = 0;
		bit emit;
		while (ic != 0 || ir != 0 || oc != 0 || orow != 0) begin
			emit = ir >= 2 || (ir == 1 && ic >= 1);
			if (ic >= w - 1) begin
				ic = 0;
				if (ir < 65535) ir++;
			end else begin
				ic++;
			end
			n++;
			if (emit) begin
				if (oc >= w - 1 && orow >= h - 1) begin
					ic = 0;
					ir = 0;
					oc = 0;
					orow = 0;
				end else if (oc >= w - 1) begin
					oc = 0;
					orow++;
				end else begin
					oc++;
				end
			end
		end
		return n;
	endfunction

	function automatic void report(string what, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] act_v);
		n_errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
	endfunction

	function automatic void queue_item(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b, logic d);
		pixel_q.push_back('{red: r, green: g, blue: b, drain: d});
		n_queued++;
	endfunction

	// Request driver: one item in flight, held stable until accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				blur_step(cur_req);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = pixel_q.pop_front();
					in_valid <= 1'b1;
					in_red   <= cur_req.red;
					in_green <= cur_req.green;
					in_blue  <= cur_req.blue;
					drain    <= cur_req.drain;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each blurred pixel with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (frame_end) n_frames++;
				if (blurred_q.size() == 0) begin
					report("unexpected result, out_red", '0, out_red);
				end else begin
					want = blurred_q.pop_front();
					if (out_red !== want.red) report("out_red", want.red, out_red);
					if (out_green !== want.green) report("out_green", want.green, out_green);
					if (out_blue !== want.blue) report("out_blue", want.blue, out_blue);
					if (frame_end !== want.last) report("frame_end", want.last, frame_end);
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	task automatic wait_accepted();
		do @(negedge clk); while (n_accepted != n_queued);
	endtask

	// Waits until every request is taken and every blurred pixel is back, then lets
	// the pipeline settle for requests that produce no result.
	task automatic wait_quiet();
		do @(negedge clk); while (n_accepted != n_queued || blurred_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
		else height_reg = val[FH_W-1:0];
		@(negedge clk);
	endtask

	task automatic align_frame();
		int unsigned n;
		wait_accepted();
		n = drains_to_frame_start();
		repeat (n) queue_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	task automatic push_frame(int unsigned w, int unsigned h, fill_t fill, int unsigned pause_at);
		int unsigned k;
		logic [CH_W-1:0] v;
		for (k = 0; k < w * h; k++) begin
			// A pause here makes the sender wait for every pending result mid-frame.
			if (pause_at != 0 && k == pause_at) wait_quiet();
			case (fill)
				FILL_WHITE: begin
					queue_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
				end
				FILL_CHECKER: begin
					v = (((k % w) + (k / w)) % 2 != 0) ? 8'hFF : 8'h00;
					queue_item(v, ~v, v, 1'b0);
				end
				default: begin
					queue_item(8'($urandom), 8'($urandom), 8'($urandom),
						$urandom_range(19) == 0);
				end
			endcase
		end
		repeat (w + 1) queue_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	task automatic random_traffic(int unsigned n);
		int unsigned start, w, h, len;
		start = n_queued;
		while (n_queued - start < n) begin
			case ($urandom_range(9))
				0: begin
					// New sizes take effect at a frame start, so every line store
					// entry inside the window has been written in this frame.
					align_frame();
					wait_quiet();
					write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'($urandom_range(12))});
					write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(7)));
				end
				1, 2: begin
					// Loose pixels and drains that break the frame structure.
					len = $urandom_range(2 * eff_width(), 1);
					repeat (len) queue_item(8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				end
				default: begin
					align_frame();
					w = eff_width();
					h = eff_height();
					push_frame(w, h, FILL_RANDOM,
						($urandom_range(3) == 0) ? $urandom_range(w * h - 1, 1) : 0);
				end
			endcase
		end
	endtask

	initial begin
		send_idle_pct = 22;
		recv_idle_pct = 49;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// At the reset size of 1024 these few pixels are all still in warm-up.
		queue_item(8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_item(8'h00, 8'hFF, 8'h00, 1'b0);
		queue_item(8'h80, 8'h7F, 8'h01, 1'b0);
		wait_quiet();
		// Shrinking the frame mid-row: the current column is past the new last column.
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd2);
		align_frame();
		wait_quiet();
		// Width 1 and height 0 both clamp to the 2x2 minimum frame.
		write_reg(REG_FRAME_WIDTH, 16'hF801);
		write_reg(REG_FRAME_HEIGHT, 16'd0);
		push_frame(2, 2, FILL_WHITE, 0);
		wait_quiet();
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		push_frame(3, 3, FILL_CHECKER, 5);

		random_traffic(180);
		send_idle_pct = 49;
		recv_idle_pct = 22;
		random_traffic(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(180);
		wait_quiet();

		$display("tb: %0d pixel requests, %0d blurred pixels compared, %0d frames closed",
			n_accepted, n_checked, n_frames);
		$display("tb: frame sizes from 2x2 up to 12x7, clamped sizes, loose items and drains");
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/bb3_pkg.sv
sv/bb3_linebuf.sv
sv/bb3_lane.sv
sv/box_blur_3x3_edge_mean_top.sv
tb/tb_box_blur_3x3_edge_mean_top.sv
